// ===== rtl/core/mahs_pkg.sv =====
// Shared types, constants and lookup tables for the MPEG audio header scanner.
package mahs_pkg;

    localparam logic [31:0] C_SYNC_MASK  = 32'hFFE0_0000;
    localparam logic [15:0] C_TOP16_BAD  = 16'hFFFE;
    localparam logic [1:0]  C_VER_MPEG1  = 2'd3;
    localparam logic [1:0]  C_VER_MPEG2  = 2'd2;
    localparam logic [1:0]  C_VER_RSVD   = 2'd1;
    localparam logic [1:0]  C_MODE_MONO  = 2'h3;
    localparam logic [3:0]  C_BRI_FREE   = 4'd0;
    localparam logic [3:0]  C_BRI_BAD    = 4'd15;
    localparam logic [1:0]  C_SRI_RSVD   = 2'd3;
    localparam logic [1:0]  C_LAYER_RSVD = 2'd0;

    // Frame factor times the kbit scale, so size = kbps * C_NUM_Vx / rate
    localparam int          C_KBIT_SCALE = 1000;
    localparam logic [17:0] C_NUM_V1     = 18'(144 * C_KBIT_SCALE);
    localparam logic [17:0] C_NUM_V2     = 18'(72 * C_KBIT_SCALE);
    localparam logic [10:0] C_SPF_V1     = 11'd1152;
    localparam logic [10:0] C_SPF_V2     = 11'd576;

    // Quotient bits of the frame size division (size stays below 2048)
    localparam int          C_QBITS      = 11;
    localparam int          C_NUM_W      = 26;
    localparam logic [3:0]  C_BIT_TOP    = 4'(C_QBITS - 1);

    localparam int          C_TDATA_IN_W  = 8;
    localparam int          C_TDATA_OUT_W = 56;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic shift;     // take the byte into the window
        logic load_num;  // decode header, start division
        logic div_step;  // one quotient bit
        logic out_load;  // move result to output register
    } t_ctrl_cmd;

    typedef struct packed {
        logic hdr_ok;    // window with incoming byte is a valid header
        logic div_last;  // current step yields the lowest quotient bit
        logic out_free;  // output register can take a result this cycle
    } t_dp_status;

    function automatic logic header_valid(input logic [31:0] h);
        logic ok;
        ok = ((h & C_SYNC_MASK) == C_SYNC_MASK);
        ok = ok && (h[20:19] != C_VER_RSVD) && (h[18:17] != C_LAYER_RSVD);
        ok = ok && (h[15:12] != C_BRI_FREE) && (h[15:12] != C_BRI_BAD);
        ok = ok && (h[11:10] != C_SRI_RSVD) && (h[31:16] != C_TOP16_BAD);
        return ok;
    endfunction

    // Layer III bitrate table
    function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [3:0] bri);
        logic [8:0] v;
        if (ver == C_VER_MPEG1) begin
            case (bri)
                4'd1:    v = 9'd32;
                4'd2:    v = 9'd40;
                4'd3:    v = 9'd48;
                4'd4:    v = 9'd56;
                4'd5:    v = 9'd64;
                4'd6:    v = 9'd80;
                4'd7:    v = 9'd96;
                4'd8:    v = 9'd112;
                4'd9:    v = 9'd128;
                4'd10:   v = 9'd160;
                4'd11:   v = 9'd192;
                4'd12:   v = 9'd224;
                4'd13:   v = 9'd256;
                4'd14:   v = 9'd320;
                default: v = 9'd0;
            endcase
        end else begin
            case (bri)
                4'd1:    v = 9'd8;
                4'd2:    v = 9'd16;
                4'd3:    v = 9'd24;
                4'd4:    v = 9'd32;
                4'd5:    v = 9'd40;
                4'd6:    v = 9'd48;
                4'd7:    v = 9'd56;
                4'd8:    v = 9'd64;
                4'd9:    v = 9'd80;
                4'd10:   v = 9'd96;
                4'd11:   v = 9'd112;
                4'd12:   v = 9'd128;
                4'd13:   v = 9'd144;
                4'd14:   v = 9'd160;
                default: v = 9'd0;
            endcase
        end
        return v;
    endfunction

    function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sri);
        logic [15:0] v;
        case (sri)
            2'd0:    v = (ver == C_VER_MPEG1) ? 16'd44100 :
                         (ver == C_VER_MPEG2) ? 16'd22050 : 16'd11025;
            2'd1:    v = (ver == C_VER_MPEG1) ? 16'd48000 :
                         (ver == C_VER_MPEG2) ? 16'd24000 : 16'd12000;
            2'd2:    v = (ver == C_VER_MPEG1) ? 16'd32000 :
                         (ver == C_VER_MPEG2) ? 16'd16000 : 16'd8000;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/mahs_ctrl.sv =====
// Sequencer for byte intake, size division and result handoff.
module mahs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  mahs_pkg::t_dp_status  i_status,
    output mahs_pkg::t_ctrl_cmd   o_cmd
);
    import mahs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_tvalid && i_status.hdr_ok) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_tready  = 1'b1;
                o_cmd.shift = s_tvalid;
            end
            ST_MUL:  o_cmd.load_num = 1'b1;
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_DONE: o_cmd.out_load = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

`ifndef ASSERT_OFF
    a_div_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_status.div_last) |=> (r_state == ST_DONE))
        else $error("division end did not reach handoff");
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.shift, o_cmd.load_num, o_cmd.div_step, o_cmd.out_load}))
        else $error("more than one datapath command");
    a_hdr_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.shift && i_status.hdr_ok) |=> (r_state == ST_MUL))
        else $error("valid header did not start sizing");
`endif

endmodule

// ===== rtl/core/mahs_datapath.sv =====
// Header window, table lookup, frame size divider and output register.
module mahs_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [mahs_pkg::C_TDATA_IN_W-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mahs_pkg::C_TDATA_OUT_W-1:0]   m_tdata,
    input  mahs_pkg::t_ctrl_cmd                  i_cmd,
    output mahs_pkg::t_dp_status                 o_status
);
    import mahs_pkg::*;

    logic [31:0]        r_window;
    logic [31:0]        n_window;
    logic [2:0]         r_fill;
    logic [1:0]         r_ver;
    logic [8:0]         r_kbps;
    logic [15:0]        r_rate;
    logic               r_pad;
    logic [1:0]         r_mode;
    logic [C_NUM_W-1:0] r_rem;
    logic [C_QBITS-1:0] r_quot;
    logic [3:0]         r_bit;
    logic               r_ovalid;
    logic [C_TDATA_OUT_W-1:0] r_odata;

    logic [8:0]         dec_kbps;
    logic [17:0]        num_k;
    logic [C_NUM_W-1:0] prod;
    logic [C_NUM_W:0]   div_shifted;
    logic [C_NUM_W:0]   div_trial;
    logic [10:0]        frame_bytes;
    logic [10:0]        spf;
    logic [1:0]         ch_count;

    assign n_window = {r_window[23:0], s_tdata};

    assign o_status.hdr_ok   = (r_fill >= 3'd3) && header_valid(n_window);
    assign o_status.div_last = (r_bit == 4'd0);
    assign o_status.out_free = !r_ovalid || m_tready;

    assign dec_kbps = kbps_lookup(r_window[20:19], r_window[15:12]);
    assign num_k    = (r_window[20:19] == C_VER_MPEG1) ? C_NUM_V1 : C_NUM_V2;
    assign prod     = C_NUM_W'(dec_kbps) * C_NUM_W'(num_k);

    assign div_shifted = (C_NUM_W+1)'(r_rate) << r_bit;
    assign div_trial   = {1'b0, r_rem} - div_shifted;

    assign frame_bytes = r_quot + 11'(r_pad);
    assign spf         = (r_ver == C_VER_MPEG1) ? C_SPF_V1 : C_SPF_V2;
    assign ch_count    = (r_mode == C_MODE_MONO) ? 2'd1 : 2'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.shift) begin
                r_window <= n_window;
                if (r_fill < 3'd4) begin
                    r_fill <= r_fill + 3'd1;
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_num) begin
            r_ver  <= r_window[20:19];
            r_kbps <= dec_kbps;
            r_rate <= rate_lookup(r_window[20:19], r_window[11:10]);
            r_pad  <= r_window[9];
            r_mode <= r_window[7:6];
            r_rem  <= prod;
            r_quot <= '0;
            r_bit  <= C_BIT_TOP;
        end
        // Restoring division, one quotient bit per cycle, top bit first
        if (i_cmd.div_step) begin
            if (!div_trial[C_NUM_W]) begin
                r_rem         <= div_trial[C_NUM_W-1:0];
                r_quot[r_bit] <= 1'b1;
            end
            r_bit <= r_bit - 4'd1;
        end
        if (i_cmd.out_load) begin
            r_odata <= {2'b00, r_pad, ch_count, r_mode, spf, frame_bytes,
                        r_rate, r_kbps, r_ver};
        end
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_odata;

`ifndef ASSERT_OFF
    a_rem_below_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (r_rem < C_NUM_W'(r_rate)))
        else $error("division remainder not below divisor");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 3'd4)
        else $error("fill count out of range");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> m_tvalid)
        else $error("result load did not raise output valid");
`endif

endmodule

// ===== rtl/core/mpeg_audio_header_scanner.sv =====
// Top level of the MPEG audio frame header scanner.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata[7:0] = data_byte
//  m_      | out | m_tvalid/m_tready  | m_tdata[55:0] = header result fields
//
// A byte whose window is not a valid header is taken without holding intake.
// A valid header then holds intake: decode and multiply (ST_MUL), a
// restoring divider for the frame size (one quotient bit a cycle),
// and a handoff of the result to the output register (ST_DONE).
// The handoff waits while a previous result is still unread on m_.
// Reset is synchronous: window, fill count, state and output valid clear.
module mpeg_audio_header_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] version_code, [10:2] bitrate_kbps, [26:11] sample_rate_hz,
    // [37:27] frame_bytes, [48:38] samples_per_frame, [50:49] channel_mode,
    // [52:51] channel_count, [53] padding_set, [55:54] zero
    output logic [55:0] m_tdata
);
    import mahs_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    mahs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mahs_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

// ===== sim/mpeg_audio_header_scanner_tb.sv =====
// Testbench for the MPEG audio header scanner: byte stream in, decoded headers checked.
`timescale 1ns / 100ps

module mpeg_audio_header_scanner_tb;
    import mahs_pkg::*;

    localparam int          IDLE_PCT     = 18;
    localparam int          BYTE_TARGET  = 1300;
    localparam int          STALL_LIMIT  = 3000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          TAIL_CYCLES  = 32;
    localparam logic [1:0]  VER_MPEG25   = 2'd0;
    localparam logic [1:0]  LAYER_III    = 2'd1;
    localparam logic [1:0]  LAYER_I      = 2'd3;
    localparam logic [10:0] SYNC_BITS    = 11'h7FF;

    typedef struct {
        logic [1:0]  version_code;
        logic [8:0]  bitrate_kbps;
        logic [15:0] sample_rate_hz;
        logic [10:0] frame_bytes;
        logic [10:0] samples_per_frame;
        logic [1:0]  channel_mode;
        logic [1:0]  channel_count;
        logic        padding_set;
    } t_header_fields;

    class header_tracker;
        logic [31:0]    window;
        int unsigned    fill;
        int unsigned    failures;
        t_header_fields expected_headers[$];
        int unsigned    kbps_mpeg1[16] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160,
                                           192, 224, 256, 320, 0};
        int unsigned    kbps_mpeg2[16] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96,
                                           112, 128, 144, 160, 0};
        int unsigned    rate_mpeg1[3]  = '{44100, 48000, 32000};

        function new();
            window   = '0;
            fill     = 0;
            failures = 0;
        endfunction

        function bit is_header(logic [31:0] h);
            return (h[31:21] == SYNC_BITS) && (h[20:19] != C_VER_RSVD) &&
                   (h[18:17] != C_LAYER_RSVD) && (h[15:12] != C_BRI_FREE) &&
                   (h[15:12] != C_BRI_BAD) && (h[11:10] != C_SRI_RSVD) &&
                   (h[31:16] != C_TOP16_BAD);
        endfunction

        // Slide the window by one accepted byte and queue the decoded header, if any
        function void take_byte(logic [7:0] b);
            t_header_fields r;
            logic [1:0]     ver;
            int unsigned    kbps;
            int unsigned    rate;
            int unsigned    factor;
            window = {window[23:0], b};
            if (fill < 4) fill++;
            if (fill < 4 || !is_header(window)) return;
            ver  = window[20:19];
            rate = rate_mpeg1[window[11:10]];
            if (ver == C_VER_MPEG1) begin
                kbps   = kbps_mpeg1[window[15:12]];
                factor = 144;
            end else begin
                kbps   = kbps_mpeg2[window[15:12]];
                factor = 72;
                rate   = (ver == C_VER_MPEG2) ? rate / 2 : rate / 4;
            end
            r.version_code      = ver;
            r.bitrate_kbps      = kbps[8:0];
            r.sample_rate_hz    = rate[15:0];
            r.padding_set       = window[9];
            r.frame_bytes       = 11'((factor * kbps * 1000) / rate + window[9]);
            r.samples_per_frame = (ver == C_VER_MPEG1) ? 11'd1152 : 11'd576;
            r.channel_mode      = window[7:6];
            r.channel_count     = (window[7:6] == C_MODE_MONO) ? 2'd1 : 2'd2;
            expected_headers.push_back(r);
        endfunction

        function void compare(string name, int unsigned exp_val, int unsigned act_val);
            if (exp_val != act_val) begin
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
                failures++;
            end
        endfunction

        function void check_header(logic [55:0] d);
            t_header_fields e;
            if (expected_headers.size() == 0) begin
                $error("result transfer with no header pending: tdata %h", d);
                failures++;
                return;
            end
            e = expected_headers.pop_front();
            compare("version_code",      e.version_code,      d[1:0]);
            compare("bitrate_kbps",      e.bitrate_kbps,      d[10:2]);
            compare("sample_rate_hz",    e.sample_rate_hz,    d[26:11]);
            compare("frame_bytes",       e.frame_bytes,       d[37:27]);
            compare("samples_per_frame", e.samples_per_frame, d[48:38]);
            compare("channel_mode",      e.channel_mode,      d[50:49]);
            compare("channel_count",     e.channel_count,     d[52:51]);
            compare("padding_set",       e.padding_set,       d[53]);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] data_byte
    logic        m_tvalid;
    logic        m_tready;
    // [1:0] version_code, [10:2] bitrate_kbps, [26:11] sample_rate_hz,
    // [37:27] frame_bytes, [48:38] samples_per_frame, [50:49] channel_mode,
    // [52:51] channel_count, [53] padding_set
    logic [55:0] m_tdata;

    header_tracker tracker;
    int unsigned   sent_count;
    int unsigned   results_seen;
    bit            steady_run;

    // Directed opening: short start, headers three bytes apart, both MPEG-2 rates,
    // Layer II at the top rate, and the 0xFFFE pattern
    logic [7:0] opening_bytes [23] = '{
        8'hFF, 8'hFB, 8'h90, 8'hFF, 8'hFB, 8'h90, 8'h64,
        8'hFF, 8'hE3, 8'h14, 8'hC0,
        8'hFF, 8'hF3, 8'hEA, 8'h00,
        8'hFF, 8'hFD, 8'hEA, 8'h80,
        8'hFF, 8'hFE, 8'h90, 8'h00
    };

    mpeg_audio_header_scanner DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        tracker.take_byte(b);
        sent_count++;
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
    endtask

    task automatic send_random_header();
        logic [1:0]  ver;
        logic [1:0]  layer;
        logic [3:0]  bri;
        logic [1:0]  sri;
        logic [31:0] w;
        case ($urandom_range(19))
            0:       ver = C_VER_RSVD;
            1, 2, 3: ver = VER_MPEG25;
            4, 5, 6: ver = C_VER_MPEG2;
            default: ver = C_VER_MPEG1;
        endcase
        layer = ($urandom_range(19) == 0) ? C_LAYER_RSVD
                                          : 2'($urandom_range(LAYER_III, LAYER_I));
        if ($urandom_range(19) == 0)
            bri = $urandom_range(1) ? C_BRI_FREE : C_BRI_BAD;
        else
            bri = 4'($urandom_range(C_BRI_FREE + 1, C_BRI_BAD - 1));
        sri = ($urandom_range(19) == 0) ? C_SRI_RSVD : 2'($urandom_range(C_SRI_RSVD - 1));
        w = $urandom;
        w[31:21] = SYNC_BITS;
        w[20:19] = ver;
        w[18:17] = layer;
        w[15:12] = bri;
        w[11:10] = sri;
        send_word(w);
    endtask

    // Receiver: random stalls, one long hold-off to back the block up
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
            end
            @(posedge i_clk);
            if (m_tvalid && m_tready) begin
                tracker.check_header(m_tdata);
                results_seen++;
                if (results_seen == 40) hold_left = HOLD_CYCLES;
            end
        end
    end

    // Abort when neither side moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        tracker      = new();
        sent_count   = 0;
        results_seen = 0;
        steady_run   = 1'b0;
        i_rst_n      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

        while (sent_count < BYTE_TARGET) begin
            steady_run = (sent_count >= 500) && (sent_count < 800);
            if ($urandom_range(99) < 75) begin
                send_random_header();
                // Trailing bytes; zero of them puts headers back to back
                repeat ($urandom_range(5)) begin
                    send_byte($urandom_range(3) == 0 ? 8'hFF : 8'($urandom));
                end
            end else begin
                repeat ($urandom_range(12, 1)) begin
                    send_byte($urandom_range(1) ? 8'($urandom) : 8'($urandom_range(255, 224)));
                end
            end
        end
        steady_run = 1'b0;
        @(negedge i_clk);
        s_tvalid <= 1'b0;

        while (tracker.expected_headers.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
